### src/jdd_pkg.sv
// shared types, constants and tables of the julian day to date converter
package jdd_pkg;

  localparam int unsigned DAY_NUMBER_W = 22;
  localparam int unsigned YEAR_W       = 14;
  localparam int unsigned MONTH_W      = 4;
  localparam int unsigned MDAY_W       = 5;

  typedef logic [DAY_NUMBER_W-1:0]  day_number_t;
  typedef logic signed [YEAR_W-1:0] year_t;
  typedef logic [MONTH_W-1:0]       month_t;
  typedef logic [MDAY_W-1:0]        mday_t;

  // calendar constants
  localparam day_number_t GREGORIAN_START = 22'd2299161;
  localparam logic [23:0] CENT_NUM_BASE   = 24'd7468865;  // 4 * 1867216 + 1
  localparam logic [22:0] EPOCH_OFFSET    = 23'd1524;
  localparam logic [28:0] YEAR_SCALE      = 29'd100;
  localparam logic [28:0] YEAR_SHIFT      = 29'd12210;
  localparam logic [22:0] DAYS_PER_YEAR   = 23'd365;
  localparam logic [14:0] YEAR_BIAS       = 15'd4715;

  // exact constant divisions by ceiling reciprocals, q = (x * RECIP) >> K
  localparam logic [63:0] CENT_DIV    = 64'd146097;
  localparam int unsigned CENT_K      = 42;
  localparam logic [63:0] CENT_RECIP_FULL =
    ((64'd1 << CENT_K) + CENT_DIV - 64'd1) / CENT_DIV;
  localparam logic [24:0] CENT_RECIP  = CENT_RECIP_FULL[24:0];

  localparam logic [63:0] YEAR_DIV    = 64'd36525;
  localparam int unsigned YEAR_K      = 45;
  localparam logic [63:0] YEAR_RECIP_FULL =
    ((64'd1 << YEAR_K) + YEAR_DIV - 64'd1) / YEAR_DIV;
  localparam logic [29:0] YEAR_RECIP  = YEAR_RECIP_FULL[29:0];

  // month term 10000*r / 306001 folded into one constant factor
  localparam logic [63:0] MONTH_DIV   = 64'd306001;
  localparam logic [63:0] MONTH_SCALE = 64'd10000;
  localparam int unsigned MONTH_K     = 42;
  localparam logic [63:0] MONTH_RECIP_FULL =
    MONTH_SCALE * (((64'd1 << MONTH_K) + MONTH_DIV - 64'd1) / MONTH_DIV);
  localparam logic [37:0] MONTH_RECIP = MONTH_RECIP_FULL[37:0];

  // day offset of month term e, floor(30.6001 * e)
  function automatic logic [8:0] month_start(input logic [4:0] e);
    logic [8:0] ms;
    case (e)
      5'd0:    ms = 9'd0;
      5'd1:    ms = 9'd30;
      5'd2:    ms = 9'd61;
      5'd3:    ms = 9'd91;
      5'd4:    ms = 9'd122;
      5'd5:    ms = 9'd153;
      5'd6:    ms = 9'd183;
      5'd7:    ms = 9'd214;
      5'd8:    ms = 9'd244;
      5'd9:    ms = 9'd275;
      5'd10:   ms = 9'd306;
      5'd11:   ms = 9'd336;
      5'd12:   ms = 9'd367;
      5'd13:   ms = 9'd397;
      5'd14:   ms = 9'd428;
      5'd15:   ms = 9'd459;
      5'd16:   ms = 9'd489;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

endpackage

### src/jdd_ifs.sv
// valid/ready channel interfaces for day numbers and calendar dates
interface jdd_day_if;
  logic                 valid;
  logic                 ready;
  jdd_pkg::day_number_t day_number;

  modport source (output valid, output day_number, input ready);
  modport sink   (input valid, input day_number, output ready);
endinterface

interface jdd_date_if;
  logic           valid;
  logic           ready;
  jdd_pkg::year_t  year;
  jdd_pkg::month_t month;
  jdd_pkg::mday_t  day;

  modport source (output valid, output year, output month, output day, input ready);
  modport sink   (input valid, input year, input month, input day, output ready);
endinterface

### src/julian_day_to_date.sv
// julian day number to calendar date converter, seven stage pipeline
//
// takes one julian day number per transfer and returns year, month and day;
// days from 2299161 on use the gregorian calendar, earlier ones the julian
// calendar, and there is no year zero (1 bc is year -1). the pipeline has
// seven register stages, and one day number is taken every cycle when the
// output side never stalls. the whole pipeline advances together: it holds
// while a finished date waits at the output register, so jdn.ready follows
// date.ready in the same cycle once the output register is full. each stage
// carries one constant multiply (reciprocal divisions by 146097, 36525 and
// 306001) or an add chain.
module julian_day_to_date (
  input  logic clk,
  input  logic rst,
  jdd_day_if.sink    jdn,
  jdd_date_if.source date
);
  import jdd_pkg::*;

  // pipeline moves when the output register is empty or being taken
  logic advance;

  // stage 1: gregorian check and century term product
  logic        s1_valid;
  day_number_t s1_day;
  logic        s1_greg;
  logic [48:0] s1_prod;
  logic        greg_in;
  logic [23:0] cent_num;

  // stage 2: shifted day count b
  logic        s2_valid;
  logic [22:0] s2_b;
  logic [6:0]  cent;
  logic [6:0]  cent_corr;

  // stage 3: scaled year numerator
  logic        s3_valid;
  logic [22:0] s3_b;
  logic [28:0] s3_num;

  // stage 4: year term product
  logic        s4_valid;
  logic [22:0] s4_b;
  logic [58:0] s4_prod;

  // stage 5: year count c and day of year r
  logic        s5_valid;
  logic [13:0] s5_c;
  logic [8:0]  s5_r;
  logic [13:0] year_c;
  logic [22:0] year_days;

  // stage 6: month term e
  logic        s6_valid;
  logic [13:0] s6_c;
  logic [8:0]  s6_r;
  logic [4:0]  s6_e;
  logic [46:0] month_prod;

  // output register
  logic          out_valid;
  year_t         out_year;
  month_t        out_month;
  mday_t         out_day;
  logic [4:0]    mon_raw;
  month_t        month_next;
  mday_t         day_next;
  logic signed [14:0] yr_base;
  logic signed [14:0] yr_adj;
  logic signed [14:0] yr_final;

  assign advance   = !out_valid || date.ready;
  assign jdn.ready = advance;

  // stage 1 logic, the century numerator is only meaningful after the switch
  assign greg_in  = jdn.day_number >= GREGORIAN_START;
  assign cent_num = greg_in ? ({jdn.day_number, 2'b00} - CENT_NUM_BASE) : '0;

  // stage 2 logic, a = d + 1 + cent - cent/4 for gregorian days
  assign cent      = s1_prod[48:42];
  assign cent_corr = s1_greg ? 7'(7'd1 + cent - (cent >> 2)) : '0;

  // stage 5 logic, days before the year start
  assign year_c    = s4_prod[58:45];
  assign year_days = 23'(year_c) * DAYS_PER_YEAR + 23'(year_c >> 2);

  // stage 6 logic
  assign month_prod = 47'(s5_r) * 47'(MONTH_RECIP);

  // output stage logic, month wraps past december into the next year
  always_comb begin
    mon_raw    = s6_e - 5'd1;
    month_next = (mon_raw > 5'd12) ? 4'(mon_raw - 5'd12) : 4'(mon_raw);
    day_next   = 5'(s6_r - month_start(s6_e));
    yr_base    = $signed({1'b0, s6_c}) - $signed(YEAR_BIAS);
    yr_adj     = (month_next > 4'd2) ? yr_base - 15'sd1 : yr_base;
    // no year zero
    yr_final   = (yr_adj <= 15'sd0) ? yr_adj - 15'sd1 : yr_adj;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= jdn.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      out_valid <= s6_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_day    <= jdn.day_number;
      s1_greg   <= greg_in;
      s1_prod   <= 49'(cent_num) * 49'(CENT_RECIP);

      s2_b      <= 23'(s1_day) + 23'(cent_corr) + EPOCH_OFFSET;

      s3_b      <= s2_b;
      s3_num    <= 29'(s2_b) * YEAR_SCALE - YEAR_SHIFT;

      s4_b      <= s3_b;
      s4_prod   <= 59'(s3_num) * 59'(YEAR_RECIP);

      s5_c      <= year_c;
      s5_r      <= 9'(s4_b - year_days);

      s6_c      <= s5_c;
      s6_r      <= s5_r;
      s6_e      <= month_prod[46:42];

      out_year  <= yr_final[13:0];
      out_month <= month_next;
      out_day   <= day_next;
    end
  end

  assign date.valid = out_valid;
  assign date.year  = out_year;
  assign date.month = out_month;
  assign date.day   = out_day;

endmodule

### src/jdd_checker.sv
// port level assertions for the julian day to date converter and their bind
module jdd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input jdd_pkg::year_t  year,
  input jdd_pkg::month_t month,
  input jdd_pkg::mday_t  day
);
  import jdd_pkg::*;

  // a held date keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) && $stable(day))
    else $error("stalled date changed");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("date valid after reset");

  // an empty output register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // every date has a month from 1 to 12 and a day from 1 to 31
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= 5'd31))
    else $error("month or day out of range");

  a_no_year_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (year != '0))
    else $error("year zero produced");

endmodule

bind julian_day_to_date jdd_checker u_jdd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (jdn.valid),
  .in_ready  (jdn.ready),
  .out_valid (date.valid),
  .out_ready (date.ready),
  .year      (date.year),
  .month     (date.month),
  .day       (date.day)
);
